>>> rtl/core/assert_macros.svh
// assertion macros for the column kinetic energy rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge out of reset
`define CKDE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be seen at a rising clock edge out of reset
`define CKDE_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> rtl/core/ckde_pkg.sv
// package: shared constants, codes and command/status types
`timescale 1ns / 1ps
package ckde_pkg;

    localparam int HALO_LEVELS = 1;
    localparam int LVL_W       = 7;
    localparam int DATA_W      = 64;

    // multiplier operand selections
    localparam logic [2:0] MUL_MX2     = 3'd0;
    localparam logic [2:0] MUL_MY2     = 3'd1;
    localparam logic [2:0] MUL_MZ2     = 3'd2;
    localparam logic [2:0] MUL_D_THIS  = 3'd3;
    localparam logic [2:0] MUL_D_BELOW = 3'd4;
    localparam logic [2:0] MUL_W2      = 3'd5;
    localparam logic [2:0] MUL_T_ABOVE = 3'd6;
    localparam logic [2:0] MUL_T_HERE  = 3'd7;

    // divider operand selections
    localparam logic DIV_H = 1'b0;
    localparam logic DIV_V = 1'b1;

    // kinds of result beat
    localparam logic [1:0] OUT_LEVEL = 2'd0;
    localparam logic [1:0] OUT_ZERO  = 2'd1;
    localparam logic [1:0] OUT_TOP   = 2'd2;

    typedef struct packed {
        logic             load_in;
        logic             acc_clear;
        logic             mul_start;
        logic [2:0]       mul_sel;
        logic             add_h;
        logic             div_start;
        logic             div_sel;
        logic             h_write;
        logic             v_write;
        logic             fault_set;
        logic             cap_vden;
        logic             out_load;
        logic [1:0]       out_kind;
        logic [LVL_W-1:0] out_level;
        logic             commit;
    } ckde_cmd_t;

    typedef struct packed {
        logic rho_zero;
        logic acc_zero;
        logic mul_busy;
        logic div_busy;
    } ckde_sts_t;

endpackage

>>> rtl/core/ckde_if.sv
// channel interfaces: level beats in, result beats out
`timescale 1ns / 1ps
interface ckde_in_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] density;
    logic signed [63:0] momentum_x;
    logic signed [63:0] momentum_y;
    logic signed [63:0] momentum_z;
    logic signed [63:0] momentum_w;
    logic signed [63:0] c2w_this;
    logic signed [63:0] c2w_below;
    logic signed [63:0] w2c_above;
    logic signed [63:0] w2c_here;

    modport source (output valid, density, momentum_x, momentum_y, momentum_z,
                    momentum_w, c2w_this, c2w_below, w2c_above, w2c_here,
                    input ready);
    modport sink (input valid, density, momentum_x, momentum_y, momentum_z,
                  momentum_w, c2w_this, c2w_below, w2c_above, w2c_here,
                  output ready);
endinterface

interface ckde_out_if;
    logic               valid;
    logic               ready;
    logic        [6:0]  level_index;
    logic signed [63:0] ke_total;
    logic signed [63:0] ke_horizontal;
    logic signed [63:0] ke_vertical;
    logic               divide_fault;
    logic               column_end;

    modport source (output valid, level_index, ke_total, ke_horizontal,
                    ke_vertical, divide_fault, column_end, input ready);
    modport sink (input valid, level_index, ke_total, ke_horizontal,
                  ke_vertical, divide_fault, column_end, output ready);
endinterface

>>> rtl/core/ckde_div.sv
// restoring divider: 192-bit by 128-bit, 64-bit saturated quotient, one bit a cycle
`timescale 1ns / 1ps
module ckde_div
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [191:0] num,
    input  logic [127:0] den,
    output logic         busy,
    output logic [63:0]  quot
);
    localparam int Q_W   = 64;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic [127:0]     rem_reg,  rem_next;
    logic [Q_W-1:0]   low_reg,  low_next;
    logic [Q_W-1:0]   q_reg,    q_next;
    logic [127:0]     den_reg,  den_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;

    logic [128:0] trial;
    logic [128:0] diff;
    logic         fits;

    // one trial subtraction per cycle
    always_comb
    begin
        trial = {rem_reg, low_reg[Q_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});
    end

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            den_next = den;
            // quotient of 2^64 or more saturates at once
            if (num[191:64] >= den)
            begin
                q_next    = '1;
                busy_next = 1'b0;
            end
            else
            begin
                rem_next  = num[191:64];
                low_next  = num[63:0];
                q_next    = '0;
                cnt_next  = CNT_W'(Q_W);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[127:0] : trial[127:0];
            low_next = {low_reg[Q_W-2:0], 1'b0};
            q_next   = {q_reg[Q_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

>>> rtl/core/ckde_datapath.sv
// datapath: operand and history registers, shared 32x32 multiplier, accumulator, divider
`timescale 1ns / 1ps
module ckde_datapath
    import ckde_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ckde_cmd_t          cmd,
    output ckde_sts_t          sts,
    input  logic signed [63:0] density,
    input  logic signed [63:0] momentum_x,
    input  logic signed [63:0] momentum_y,
    input  logic signed [63:0] momentum_z,
    input  logic signed [63:0] momentum_w,
    input  logic signed [63:0] c2w_this,
    input  logic signed [63:0] c2w_below,
    input  logic signed [63:0] w2c_above,
    input  logic signed [63:0] w2c_here,
    output logic [LVL_W-1:0]   level_index,
    output logic signed [63:0] ke_total,
    output logic signed [63:0] ke_horizontal,
    output logic signed [63:0] ke_vertical,
    output logic               divide_fault,
    output logic               column_end
);
    function automatic logic [63:0] mag64(input logic [63:0] x);
        mag64 = x[63] ? (64'd0 - x) : x;
    endfunction

    function automatic logic [63:0] sat_q(input logic [63:0] q, input logic neg);
        if (neg)
        begin
            sat_q = q[63] ? 64'h8000_0000_0000_0000 : (64'd0 - q);
        end
        else
        begin
            sat_q = q[63] ? 64'h7FFF_FFFF_FFFF_FFFF : q;
        end
    endfunction

    // current beat
    logic [63:0] rho_reg, mx_reg, my_reg, mz_reg, mw_reg;
    logic [63:0] cthis_reg, cbelow_reg, wab_reg, whe_reg;
    // results of the current beat
    logic [63:0] h_reg, v_reg;
    logic        fault_reg;
    // history from the previous beat
    logic [63:0] pdens_reg, ph_reg, pv_reg, pwab_reg, pwhe_reg;
    logic        pfault_reg;
    // vertical divisor
    logic [127:0] vden_reg;
    logic         vneg_reg;
    // accumulator and multiplier
    logic [191:0] acc_reg;
    logic [63:0]  ma_reg, mb_reg;
    logic         mneg_reg;
    logic [1:0]   mstep_reg;
    logic         mbusy_reg;
    // result register
    logic [LVL_W-1:0] lvl_reg;
    logic [63:0]      tot_reg, oh_reg, ov_reg;
    logic             of_reg, oe_reg;

    logic [63:0]  op_a, op_b;
    logic [31:0]  pa, pb;
    logic [63:0]  pp;
    logic [191:0] term;
    logic [191:0] div_num;
    logic [127:0] div_den;
    logic         div_busy;
    logic [63:0]  div_q;
    logic [63:0]  total;

    // multiplier operand selection
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_MX2:     begin op_a = mx_reg;    op_b = mx_reg;    end
            MUL_MY2:     begin op_a = my_reg;    op_b = my_reg;    end
            MUL_MZ2:     begin op_a = mz_reg;    op_b = mz_reg;    end
            MUL_D_THIS:  begin op_a = cthis_reg; op_b = rho_reg;   end
            MUL_D_BELOW: begin op_a = cbelow_reg; op_b = pdens_reg; end
            MUL_W2:      begin op_a = mw_reg;    op_b = mw_reg;    end
            MUL_T_ABOVE: begin op_a = pwab_reg;  op_b = v_reg;     end
            MUL_T_HERE:  begin op_a = pwhe_reg;  op_b = pv_reg;    end
            default:     begin op_a = '0;        op_b = '0;        end
        endcase
    end

    // one partial product per cycle, placed by step
    always_comb
    begin
        pa = mstep_reg[0] ? ma_reg[63:32] : ma_reg[31:0];
        pb = mstep_reg[1] ? mb_reg[63:32] : mb_reg[31:0];
        pp = pa * pb;
        if (mstep_reg == 2'd3)
        begin
            term = {64'd0, pp, 64'd0};
        end
        else if (mstep_reg != 2'd0)
        begin
            term = {96'd0, pp, 32'd0};
        end
        else
        begin
            term = {128'd0, pp};
        end
    end

    // divider operands
    always_comb
    begin
        if (cmd.div_sel == DIV_V)
        begin
            div_num = {acc_reg[160:0], 31'd0};
            div_den = vden_reg;
        end
        else
        begin
            div_num = acc_reg;
            div_den = {63'd0, mag64(rho_reg), 1'b0};
        end
    end

    ckde_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_q)
    );

    // total: floor to q31.32 and saturate
    always_comb
    begin
        if (acc_reg[191:95] != {97{acc_reg[191]}})
        begin
            total = acc_reg[191] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end
        else
        begin
            total = acc_reg[95:32];
        end
    end

    // multiplier control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbusy_reg <= 1'b0;
            mstep_reg <= 2'd0;
        end
        else if (cmd.mul_start)
        begin
            mbusy_reg <= 1'b1;
            mstep_reg <= 2'd0;
        end
        else if (mbusy_reg)
        begin
            mstep_reg <= mstep_reg + 2'd1;
            if (mstep_reg == 2'd3)
            begin
                mbusy_reg <= 1'b0;
            end
        end
    end

    // accumulator and operand magnitudes
    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            ma_reg   <= mag64(op_a);
            mb_reg   <= mag64(op_b);
            mneg_reg <= op_a[63] ^ op_b[63];
        end
        if (cmd.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (mbusy_reg)
        begin
            acc_reg <= mneg_reg ? (acc_reg - term) : (acc_reg + term);
        end
        else if (cmd.add_h)
        begin
            acc_reg <= acc_reg + {{96{ph_reg[63]}}, ph_reg, 32'd0};
        end
        if (cmd.cap_vden)
        begin
            vneg_reg <= acc_reg[191];
            vden_reg <= acc_reg[191] ? (128'd0 - acc_reg[127:0]) : acc_reg[127:0];
        end
    end

    // beat capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            rho_reg    <= density;
            mx_reg     <= momentum_x;
            my_reg     <= momentum_y;
            mz_reg     <= momentum_z;
            mw_reg     <= momentum_w;
            cthis_reg  <= c2w_this;
            cbelow_reg <= c2w_below;
            wab_reg    <= w2c_above;
            whe_reg    <= w2c_here;
        end
    end

    // per-level energies and fault, then history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg      <= '0;
            v_reg      <= '0;
            fault_reg  <= 1'b0;
            pdens_reg  <= '0;
            ph_reg     <= '0;
            pv_reg     <= '0;
            pwab_reg   <= '0;
            pwhe_reg   <= '0;
            pfault_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_in)
            begin
                h_reg     <= '0;
                v_reg     <= '0;
                fault_reg <= 1'b0;
            end
            if (cmd.h_write)
            begin
                h_reg <= sat_q(div_q, rho_reg[63]);
            end
            if (cmd.v_write)
            begin
                v_reg <= sat_q(div_q, vneg_reg);
            end
            if (cmd.fault_set)
            begin
                fault_reg <= 1'b1;
            end
            if (cmd.commit)
            begin
                pdens_reg  <= rho_reg;
                ph_reg     <= h_reg;
                pv_reg     <= v_reg;
                pwab_reg   <= wab_reg;
                pwhe_reg   <= whe_reg;
                pfault_reg <= fault_reg;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            lvl_reg <= cmd.out_level;
            case (cmd.out_kind)
                OUT_LEVEL:
                begin
                    tot_reg <= total;
                    oh_reg  <= ph_reg;
                    ov_reg  <= pv_reg;
                    of_reg  <= pfault_reg;
                    oe_reg  <= 1'b0;
                end
                OUT_TOP:
                begin
                    tot_reg <= '0;
                    oh_reg  <= '0;
                    ov_reg  <= '0;
                    of_reg  <= 1'b0;
                    oe_reg  <= 1'b1;
                end
                default:
                begin
                    tot_reg <= '0;
                    oh_reg  <= '0;
                    ov_reg  <= '0;
                    of_reg  <= 1'b0;
                    oe_reg  <= 1'b0;
                end
            endcase
        end
    end

    // status to the controller
    always_comb
    begin
        sts.rho_zero = (rho_reg == 64'd0);
        sts.acc_zero = (acc_reg == 192'd0);
        sts.mul_busy = mbusy_reg;
        sts.div_busy = div_busy;
    end

    assign level_index   = lvl_reg;
    assign ke_total      = tot_reg;
    assign ke_horizontal = oh_reg;
    assign ke_vertical   = ov_reg;
    assign divide_fault  = of_reg;
    assign column_end    = oe_reg;

endmodule

>>> rtl/core/ckde_ctrl.sv
// controller: level counter, config register, sequencing of the datapath
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ckde_ctrl
    import ckde_pkg::*;
#(
    parameter int MAX_LEVELS = 128
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [7:0] cfg_data,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output ckde_cmd_t cmd,
    input  ckde_sts_t sts
);
    localparam int         LVL_CAP  = (MAX_LEVELS < 128) ? MAX_LEVELS : 128;
    localparam logic [7:0] LVL_CAP8 = 8'(LVL_CAP);
    localparam logic [7:0] HALO8    = 8'(HALO_LEVELS);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_H_CHK  = 5'd1;
    localparam logic [4:0] S_H_M1   = 5'd2;
    localparam logic [4:0] S_H_M2   = 5'd3;
    localparam logic [4:0] S_H_M3   = 5'd4;
    localparam logic [4:0] S_H_DIV  = 5'd5;
    localparam logic [4:0] S_H_WR   = 5'd6;
    localparam logic [4:0] S_V_CHK  = 5'd7;
    localparam logic [4:0] S_V_M1   = 5'd8;
    localparam logic [4:0] S_V_M2   = 5'd9;
    localparam logic [4:0] S_V_ZCHK = 5'd10;
    localparam logic [4:0] S_V_M3   = 5'd11;
    localparam logic [4:0] S_V_DIV  = 5'd12;
    localparam logic [4:0] S_V_WR   = 5'd13;
    localparam logic [4:0] S_T_CHK  = 5'd14;
    localparam logic [4:0] S_T_M1   = 5'd15;
    localparam logic [4:0] S_T_M2   = 5'd16;
    localparam logic [4:0] S_T_ADD  = 5'd17;
    localparam logic [4:0] S_OUT1   = 5'd18;
    localparam logic [4:0] S_TOPCHK = 5'd19;
    localparam logic [4:0] S_OUT2   = 5'd20;
    localparam logic [4:0] S_FIN    = 5'd21;
    localparam logic [4:0] S_WAIT   = 5'd22;

    logic [4:0]       state_reg, state_next;
    logic [4:0]       ret_reg,   ret_next;
    logic [LVL_W-1:0] cnt_reg,   cnt_next;
    logic [7:0]       cfg_reg;
    logic             out_valid_reg, out_valid_next;

    logic [7:0]       eff, top8, cnt8, lvl8;
    logic [LVL_W-1:0] lvl;
    logic             is_top, do_h, do_v, emit1, interior1, slot_free;

    // level bookkeeping from the counter and the clamped level count
    always_comb
    begin
        eff = cfg_reg;
        if (cfg_reg < 8'd4)
        begin
            eff = 8'd4;
        end
        else if (cfg_reg > LVL_CAP8)
        begin
            eff = LVL_CAP8;
        end
        top8      = eff - HALO8;
        cnt8      = {1'b0, cnt_reg};
        lvl       = cnt_reg - 7'd1;
        lvl8      = {1'b0, lvl};
        is_top    = (cnt8 >= top8);
        do_h      = !is_top && (cnt8 >= HALO8);
        do_v      = !is_top && (cnt8 >= HALO8 + 8'd1);
        emit1     = (cnt_reg != '0);
        interior1 = emit1 && (lvl8 >= HALO8) && (lvl8 < top8);
        slot_free = !out_valid_reg || out_ready;
    end

    // sequencer
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ret_next   = ret_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_H_CHK;
                end
            end
            S_H_CHK:
            begin
                if (!do_h)
                begin
                    state_next = S_V_CHK;
                end
                else if (sts.rho_zero)
                begin
                    cmd.fault_set = 1'b1;
                    state_next    = S_V_CHK;
                end
                else
                begin
                    cmd.acc_clear = 1'b1;
                    state_next    = S_H_M1;
                end
            end
            S_H_M1:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_MX2;
                ret_next      = S_H_M2;
                state_next    = S_WAIT;
            end
            S_H_M2:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_MY2;
                ret_next      = S_H_M3;
                state_next    = S_WAIT;
            end
            S_H_M3:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_MZ2;
                ret_next      = S_H_DIV;
                state_next    = S_WAIT;
            end
            S_H_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_H;
                ret_next      = S_H_WR;
                state_next    = S_WAIT;
            end
            S_H_WR:
            begin
                cmd.h_write = 1'b1;
                state_next  = S_V_CHK;
            end
            S_V_CHK:
            begin
                if (!do_v)
                begin
                    state_next = S_T_CHK;
                end
                else
                begin
                    cmd.acc_clear = 1'b1;
                    state_next    = S_V_M1;
                end
            end
            S_V_M1:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_D_THIS;
                ret_next      = S_V_M2;
                state_next    = S_WAIT;
            end
            S_V_M2:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_D_BELOW;
                ret_next      = S_V_ZCHK;
                state_next    = S_WAIT;
            end
            S_V_ZCHK:
            begin
                if (sts.acc_zero)
                begin
                    cmd.fault_set = 1'b1;
                    state_next    = S_T_CHK;
                end
                else
                begin
                    cmd.cap_vden  = 1'b1;
                    cmd.acc_clear = 1'b1;
                    state_next    = S_V_M3;
                end
            end
            S_V_M3:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_W2;
                ret_next      = S_V_DIV;
                state_next    = S_WAIT;
            end
            S_V_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_V;
                ret_next      = S_V_WR;
                state_next    = S_WAIT;
            end
            S_V_WR:
            begin
                cmd.v_write = 1'b1;
                state_next  = S_T_CHK;
            end
            S_T_CHK:
            begin
                if (!emit1)
                begin
                    state_next = S_TOPCHK;
                end
                else if (!interior1)
                begin
                    state_next = S_OUT1;
                end
                else
                begin
                    cmd.acc_clear = 1'b1;
                    state_next    = S_T_M1;
                end
            end
            S_T_M1:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_T_ABOVE;
                ret_next      = S_T_M2;
                state_next    = S_WAIT;
            end
            S_T_M2:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_T_HERE;
                ret_next      = S_T_ADD;
                state_next    = S_WAIT;
            end
            S_T_ADD:
            begin
                cmd.add_h  = 1'b1;
                state_next = S_OUT1;
            end
            S_OUT1:
            begin
                if (slot_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_kind  = interior1 ? OUT_LEVEL : OUT_ZERO;
                    cmd.out_level = lvl;
                    state_next    = S_TOPCHK;
                end
            end
            S_TOPCHK:
            begin
                state_next = is_top ? S_OUT2 : S_FIN;
            end
            S_OUT2:
            begin
                if (slot_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_kind  = OUT_TOP;
                    cmd.out_level = cnt_reg;
                    state_next    = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.commit = 1'b1;
                cnt_next   = is_top ? '0 : cnt_reg + 7'd1;
                state_next = S_IDLE;
            end
            S_WAIT:
            begin
                if (!sts.mul_busy && !sts.div_busy)
                begin
                    state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result valid: set on load, cleared when the beat is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            cnt_reg       <= '0;
            cfg_reg       <= 8'd96;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_data;
            end
        end
    end

    assign out_valid = out_valid_reg;

    // checks
    `CKDE_ASSERT(a_mul_units_free, cmd.mul_start |-> (!sts.mul_busy && !sts.div_busy), "multiply started while an arithmetic unit is busy")
    `CKDE_ASSERT(a_out_slot_free, cmd.out_load |-> (!out_valid_reg || out_ready), "result register overwritten before its beat was taken")
    `CKDE_ASSERT(a_cnt_step, (state_reg == S_FIN) |=> (cnt_reg == '0 || cnt_reg == $past(cnt_reg) + 7'd1), "level counter moved by other than one step or a restart")
    `CKDE_NEVER(a_accept_idle_units, in_valid && in_ready && (sts.mul_busy || sts.div_busy), "beat accepted while an arithmetic unit is busy")

endmodule

>>> rtl/core/column_kinetic_energy.sv
// top level: column kinetic energy, controller plus datapath
//
//  channel  | dir | beat                                         | handshake
//  ---------+-----+----------------------------------------------+-------------
//  in_ch    | in  | one level: density, momenta, weights         | valid/ready
//  out_ch   | out | level_index, three energies, fault, end flag | valid/ready
//  cfg      | in  | levels_in_use, 8 bits                        | cfg_we
//
//  an interior level makes two runs of the shared divider (a start, then up to 64 steps)
//  and eight 64x64 products on one 32x32 multiplier, plus the checks and the beat out.
//  rst_n is asynchronous, active low; levels_in_use resets to 96 and the counter to 0.
//  the result register holds one beat; the next beat is accepted while it waits,
//  and the sequencer holds in an output state only while the register is still full.
`timescale 1ns / 1ps
module column_kinetic_energy
    import ckde_pkg::*;
#(
    parameter int MAX_LEVELS = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_data,
    ckde_in_if.sink    in_ch,
    ckde_out_if.source out_ch
);
    ckde_cmd_t cmd;
    ckde_sts_t sts;

    ckde_ctrl #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    ckde_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .density       (in_ch.density),
        .momentum_x    (in_ch.momentum_x),
        .momentum_y    (in_ch.momentum_y),
        .momentum_z    (in_ch.momentum_z),
        .momentum_w    (in_ch.momentum_w),
        .c2w_this      (in_ch.c2w_this),
        .c2w_below     (in_ch.c2w_below),
        .w2c_above     (in_ch.w2c_above),
        .w2c_here      (in_ch.w2c_here),
        .level_index   (out_ch.level_index),
        .ke_total      (out_ch.ke_total),
        .ke_horizontal (out_ch.ke_horizontal),
        .ke_vertical   (out_ch.ke_vertical),
        .divide_fault  (out_ch.divide_fault),
        .column_end    (out_ch.column_end)
    );

endmodule

>>> tb/sv/tb.sv
// testbench for column_kinetic_energy: random and directed level beats, self-checking
`timescale 1ns / 1ps
module tb;
    import ckde_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 400;

    typedef struct packed {
        logic signed [63:0] density;
        logic signed [63:0] momentum_x;
        logic signed [63:0] momentum_y;
        logic signed [63:0] momentum_z;
        logic signed [63:0] momentum_w;
        logic signed [63:0] c2w_this;
        logic signed [63:0] c2w_below;
        logic signed [63:0] w2c_above;
        logic signed [63:0] w2c_here;
    } level_beat_t;

    typedef struct packed {
        logic [6:0]         level_index;
        logic signed [63:0] ke_total;
        logic signed [63:0] ke_horizontal;
        logic signed [63:0] ke_vertical;
        logic               divide_fault;
        logic               column_end;
    } energy_beat_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_data;

    ckde_in_if  in_ch();
    ckde_out_if out_ch();

    column_kinetic_energy i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    level_beat_t  level_q[$];
    energy_beat_t energy_q[$];
    int           errors;
    int           quiet_cycles;
    bit           calm;
    logic         in_taken;

    // predictor state
    logic [7:0]         p_levels;
    logic [6:0]         p_counter;
    logic signed [63:0] p_density;
    logic signed [63:0] p_kh;
    logic signed [63:0] p_kv;
    logic signed [63:0] p_above;
    logic signed [63:0] p_here;
    logic               p_fault;

    // clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic signed [191:0] wide_mul(logic signed [63:0] a,
                                                     logic signed [63:0] b);
        logic signed [191:0] x;
        logic signed [191:0] y;
        x = a;
        y = b;
        return x * y;
    endfunction

    function automatic logic [63:0] magnitude(logic signed [63:0] a);
        return a[63] ? -a : a;
    endfunction

    // saturate an unsigned quotient with a sign into Q31.32
    function automatic logic [63:0] clamp_quotient(logic [191:0] q, logic neg);
        logic [63:0] m;
        m = (q[191:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
        if (neg)
            return (m >= 64'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000 : -m;
        return (m > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : m;
    endfunction

    // energies of one accepted level, queue of the results it releases
    function automatic void predict_level(level_beat_t b);
        logic [7:0]          eff;
        logic [6:0]          top;
        logic [6:0]          k;
        logic                is_top;
        logic signed [63:0]  h;
        logic signed [63:0]  v;
        logic                fault;
        logic [191:0]        sq_sum;
        logic [191:0]        num;
        logic [191:0]        dmag;
        logic [63:0]         rm;
        logic [63:0]         wm;
        logic [63:0]         m;
        logic signed [191:0] dsum;
        logic signed [191:0] acc;
        logic signed [191:0] kh_ext;
        energy_beat_t        e;
        eff = (p_levels < 8'd4) ? 8'd4 : (p_levels > 8'd128) ? 8'd128 : p_levels;
        top = 7'(eff - 8'd1);
        k = p_counter;
        is_top = ({1'b0, k} >= {1'b0, eff - 8'd1});
        h = '0;
        v = '0;
        fault = 1'b0;
        // horizontal energy
        if (!is_top && k >= 7'd1)
        begin
            if (b.density == 0)
                fault = 1'b1;
            else
            begin
                rm = magnitude(b.density);
                m = magnitude(b.momentum_x);
                sq_sum = {128'b0, m} * {128'b0, m};
                m = magnitude(b.momentum_y);
                sq_sum = sq_sum + {128'b0, m} * {128'b0, m};
                m = magnitude(b.momentum_z);
                sq_sum = sq_sum + {128'b0, m} * {128'b0, m};
                h = clamp_quotient(sq_sum / ({128'b0, rm} << 1), b.density[63]);
            end
        end
        // vertical energy on the lower face
        if (!is_top && k >= 7'd2)
        begin
            dsum = wide_mul(b.c2w_this, b.density) + wide_mul(b.c2w_below, p_density);
            if (dsum == 0)
                fault = 1'b1;
            else
            begin
                dmag = dsum[191] ? -dsum : dsum;
                wm = magnitude(b.momentum_w);
                num = ({128'b0, wm} * {128'b0, wm}) << 31;
                v = clamp_quotient(num / dmag, dsum[191]);
            end
        end
        // total for the level below
        if (k >= 7'd1)
        begin
            e = '0;
            e.level_index = k - 7'd1;
            if (k - 7'd1 >= 7'd1 && k - 7'd1 < top)
            begin
                kh_ext = p_kh;
                acc = wide_mul(p_above, v) + wide_mul(p_here, p_kv) + (kh_ext <<< 32);
                if (acc[191] ? (&acc[191:95]) : !(|acc[191:95]))
                    e.ke_total = acc[95:32];
                else
                    e.ke_total = acc[191] ? 64'h8000_0000_0000_0000
                                          : 64'h7FFF_FFFF_FFFF_FFFF;
                e.ke_horizontal = p_kh;
                e.ke_vertical = p_kv;
                e.divide_fault = p_fault;
            end
            energy_q.push_back(e);
        end
        if (is_top)
        begin
            e = '0;
            e.level_index = k;
            e.column_end = 1'b1;
            energy_q.push_back(e);
            p_counter = '0;
        end
        else
            p_counter = k + 7'd1;
        p_density = b.density;
        p_kh = h;
        p_kv = v;
        p_above = b.w2c_above;
        p_here = b.w2c_here;
        p_fault = fault;
    endfunction

    // field value biased towards extremes and unit values
    function automatic logic signed [63:0] pick_value();
        case ($urandom_range(0, 15))
            0: return 64'sd0;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'sh1_0000_0000;
            4: return -64'sh1_0000_0000;
            5: return 64'sd1;
            6: return -64'sd1;
            7, 8, 9, 10: return $signed({{24{$urandom_range(0, 1) == 1}}, 8'($urandom),
                                         32'($urandom)});
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic level_beat_t random_level();
        level_beat_t b;
        b.density = pick_value();
        b.momentum_x = pick_value();
        b.momentum_y = pick_value();
        b.momentum_z = pick_value();
        b.momentum_w = pick_value();
        b.c2w_this = pick_value();
        b.c2w_below = pick_value();
        b.w2c_above = pick_value();
        b.w2c_here = pick_value();
        return b;
    endfunction

    // driver: next level beat at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_ch.valid || in_taken)
            begin
                if (level_q.size() > 0 && (calm || $urandom_range(0, 99) >= 12))
                begin
                    {in_ch.density, in_ch.momentum_x, in_ch.momentum_y, in_ch.momentum_z,
                     in_ch.momentum_w, in_ch.c2w_this, in_ch.c2w_below, in_ch.w2c_above,
                     in_ch.w2c_here} <= level_q.pop_front();
                    in_ch.valid <= 1'b1;
                end
                else
                    in_ch.valid <= 1'b0;
            end
            out_ch.ready <= calm || ($urandom_range(0, 99) >= 12);
        end
    end

    // monitor: accepted beats, register writes, comparison and watchdog
    always @(posedge clk)
    begin
        energy_beat_t got;
        energy_beat_t want;
        if (rst_n)
        begin
            in_taken <= in_ch.valid && in_ch.ready;
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (cfg_we)
                p_levels = cfg_data;
            if (in_ch.valid && in_ch.ready)
            begin
                predict_level({in_ch.density, in_ch.momentum_x, in_ch.momentum_y,
                               in_ch.momentum_z, in_ch.momentum_w, in_ch.c2w_this,
                               in_ch.c2w_below, in_ch.w2c_above, in_ch.w2c_here});
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got = {out_ch.level_index, out_ch.ke_total, out_ch.ke_horizontal,
                       out_ch.ke_vertical, out_ch.divide_fault, out_ch.column_end};
                if (energy_q.size() == 0)
                begin
                    $error("unexpected result beat, level_index %0d", got.level_index);
                    errors++;
                end
                else
                begin
                    want = energy_q.pop_front();
                    if (got.level_index !== want.level_index)
                    begin
                        $error("level_index expected %0d got %0d", want.level_index,
                               got.level_index);
                        errors++;
                    end
                    if (got.ke_total !== want.ke_total)
                    begin
                        $error("ke_total expected %h got %h", want.ke_total, got.ke_total);
                        errors++;
                    end
                    if (got.ke_horizontal !== want.ke_horizontal)
                    begin
                        $error("ke_horizontal expected %h got %h", want.ke_horizontal,
                               got.ke_horizontal);
                        errors++;
                    end
                    if (got.ke_vertical !== want.ke_vertical)
                    begin
                        $error("ke_vertical expected %h got %h", want.ke_vertical,
                               got.ke_vertical);
                        errors++;
                    end
                    if (got.divide_fault !== want.divide_fault)
                    begin
                        $error("divide_fault expected %b got %b", want.divide_fault,
                               got.divide_fault);
                        errors++;
                    end
                    if (got.column_end !== want.column_end)
                    begin
                        $error("column_end expected %b got %b", want.column_end,
                               got.column_end);
                        errors++;
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // wait until every queued beat is in and every result is out
    task automatic drain();
        while (level_q.size() > 0 || in_ch.valid || energy_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_levels(input logic [7:0] lv);
        drain();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= lv;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        logic [7:0]         phase_levels[12];
        int                 phase_items[12];
        logic signed [63:0] pattern[6];
        level_beat_t        b;
        errors = 0;
        quiet_cycles = 0;
        calm = 1'b0;
        in_taken = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        {in_ch.density, in_ch.momentum_x, in_ch.momentum_y, in_ch.momentum_z,
         in_ch.momentum_w, in_ch.c2w_this, in_ch.c2w_below, in_ch.w2c_above,
         in_ch.w2c_here} = '0;
        out_ch.ready = 1'b0;
        p_levels = 8'd96;
        p_counter = '0;
        p_density = '0;
        p_kh = '0;
        p_kv = '0;
        p_above = '0;
        p_here = '0;
        p_fault = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // shortest columns, each beat with every field at one pattern value, one density per column from the next value
        pattern = '{64'sd0, 64'sd1, -64'sd1, 64'h8000_0000_0000_0000,
                    64'h7FFF_FFFF_FFFF_FFFF, 64'sh1_0000_0000};
        write_levels(8'd4);
        for (int c = 0; c < 6; c++)
            for (int i = 0; i < 4; i++)
            begin
                b = {9{pattern[c]}};
                if (i == 2)
                    b.density = pattern[(c + 1) % 6];
                level_q.push_back(b);
            end

        // random phases across column heights, clamped values included
        phase_levels = '{8'd0, 8'd3, 8'd4, 8'd7, 8'd12, 8'd255,
                         8'd200, 8'd128, 8'd5, 8'd9, 8'd130, 8'd6};
        phase_items  = '{130, 130, 130, 130, 130, 260, 260, 260, 130, 130, 260, 130};
        for (int p = 0; p < 12; p++)
        begin
            write_levels(phase_levels[p]);
            calm = (p == 3);
            for (int i = 0; i < phase_items[p]; i++)
                level_q.push_back(random_level());
        end

        drain();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/ckde_pkg.sv
rtl/core/ckde_if.sv
rtl/core/ckde_div.sv
rtl/core/ckde_datapath.sv
rtl/core/ckde_ctrl.sv
rtl/core/column_kinetic_energy.sv
tb/sv/tb.sv
